[rtl/multi_buffer_slot_manager_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the slot manager, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_BUFFER_SLOT_MANAGER_ASSERT_SVH
`define MULTI_BUFFER_SLOT_MANAGER_ASSERT_SVH

`ifndef SYNTHESIS
`define MBSM_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MBSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MBSM_ASSERT(label, clk, rst_n, cond, msg)
`define MBSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/mbsm_pkg.sv]
// ----------------------------------------------------------------------------
// Slot manager package
// Widths, operation codes, word layouts and slot pick helpers.
// ----------------------------------------------------------------------------
package mbsm_pkg;

    localparam int SLOT_COUNT = 3;
    localparam int IDX_W      = 3;
    localparam int PIN_W      = 8;
    localparam int STAMP_W    = 63;
    localparam int OP_W       = 3;
    localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int S_TDATA_W  = ((STAMP_W + PIN_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = OP_W;
    localparam int M_FIELD_W  = 3 * IDX_W + PIN_W + 2 * STAMP_W;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELD_W;
    localparam int M_TUSER_W  = 1;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE      = 3'd0,
        OP_PUBLISH      = 3'd1,
        OP_BEGIN_READ   = 3'd2,
        OP_END_READ     = 3'd3,
        OP_READ_CURRENT = 3'd4
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [STAMP_W-1:0] stamp;
        logic [PIN_W-1:0]   release_mask;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] write_slot;
        logic [IDX_W-1:0] prev_slot;
        logic [IDX_W-1:0] curr_slot;
        logic             granted;
        logic [PIN_W-1:0] read_mask;
        logic             use_prev;
        logic             use_curr;
    } t_result;

    function automatic logic [PIN_W-1:0] slot_bit(input logic [IDX_W-1:0] idx);
        logic [PIN_W-1:0] b;
        b      = '0;
        b[idx] = 1'b1;
        return b;
    endfunction

    // lowest free slot, else lowest slot that is not current, else slot zero
    function automatic logic [IDX_W-1:0] pick_slot(
        input logic [IDX_W-1:0] prev,
        input logic [IDX_W-1:0] curr,
        input logic [PIN_W-1:0] pin
    );
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
        logic             found_first;
        logic             found_second;
        first        = '0;
        second       = '0;
        found_first  = 1'b0;
        found_second = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (IDX_W'(i) != prev && IDX_W'(i) != curr && !pin[i]) begin
                first       = IDX_W'(i);
                found_first = 1'b1;
            end
            if (IDX_W'(i) != curr) begin
                second       = IDX_W'(i);
                found_second = 1'b1;
            end
        end
        if (found_first) begin
            return first;
        end else if (found_second) begin
            return second;
        end
        return '0;
    endfunction

endpackage

[rtl/multi_buffer_slot_manager.sv]
// ----------------------------------------------------------------------------
// Multi buffer slot manager
// Tracks write, previous and current slots, reader pins and slot stamps.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; a result stall holds both.
// Throughput: one word per cycle while i_m_tready does not stall the result register.
// Stamp read: registered RAM read issued with the state update.
// Reset: synchronous, active low; clears indices, pins, stamp valid bits and valid flags.
// A stamp never written reads as zero; no clearing pass is needed.
module multi_buffer_slot_manager (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // stamp[62:0], release_mask[70:63], zero fill
    input  logic [mbsm_pkg::S_TDATA_W-1:0] i_s_tdata,
    // op[2:0]
    input  logic [mbsm_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // write_slot[2:0], prev_slot[5:3], curr_slot[8:6], read_mask[16:9],
    // prev_stamp[79:17], curr_stamp[142:80], zero fill
    output logic [mbsm_pkg::M_TDATA_W-1:0] o_m_tdata,
    // granted[0]
    output logic [mbsm_pkg::M_TUSER_W-1:0] o_m_tuser
);

    localparam int IW = mbsm_pkg::IDX_W;
    localparam int PW = mbsm_pkg::PIN_W;
    localparam int SW = mbsm_pkg::STAMP_W;
    localparam int AW = mbsm_pkg::SLOT_AW;
    localparam int SC = mbsm_pkg::SLOT_COUNT;

    logic                r_in_valid;
    mbsm_pkg::t_in_word  r_in;
    logic                r_out_valid;
    mbsm_pkg::t_result   r_out;
    mbsm_pkg::t_result   n_out;

    logic [IW-1:0] r_prev,  n_prev;
    logic [IW-1:0] r_curr,  n_curr;
    logic [IW-1:0] r_write, n_write;
    logic [PW-1:0] r_pin,   n_pin;
    logic [SC-1:0] r_svalid, n_svalid;

    logic          adv;
    logic          fire;
    logic          stamp_we;
    logic          grant;
    logic [PW-1:0] want;
    logic [SW-1:0] ram_prev;
    logic [SW-1:0] ram_curr;
    logic [SW-1:0] prev_stamp;
    logic [SW-1:0] curr_stamp;

    assign adv        = !r_out_valid || i_m_tready;
    assign fire       = adv && r_in_valid;
    assign o_s_tready = !r_in_valid || adv;
    assign want       = mbsm_pkg::slot_bit(r_prev) | mbsm_pkg::slot_bit(r_curr);

    always_comb begin
        n_prev   = r_prev;
        n_curr   = r_curr;
        n_write  = r_write;
        n_pin    = r_pin;
        n_svalid = r_svalid;
        stamp_we = 1'b0;
        grant    = 1'b0;
        unique case (r_in.op)
            mbsm_pkg::OP_ACQUIRE: begin
                n_write = mbsm_pkg::pick_slot(r_prev, r_curr, r_pin);
            end
            mbsm_pkg::OP_PUBLISH: begin
                stamp_we                   = 1'b1;
                n_svalid[r_write[AW-1:0]]  = 1'b1;
                n_prev                     = r_curr;
                n_curr                     = r_write;
            end
            mbsm_pkg::OP_BEGIN_READ: begin
                if ((r_pin & want) == '0) begin
                    grant = 1'b1;
                    n_pin = r_pin | want;
                end
            end
            mbsm_pkg::OP_END_READ: begin
                n_pin = r_pin & ~r_in.release_mask;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out.write_slot = n_write;
        n_out.prev_slot  = n_prev;
        n_out.curr_slot  = n_curr;
        n_out.granted    = grant;
        n_out.read_mask  = grant ? want : '0;
        n_out.use_prev   = grant && r_svalid[r_prev[AW-1:0]];
        n_out.use_curr   = grant && r_svalid[r_curr[AW-1:0]];
    end

    mbsm_ram #(
        .WIDTH (SW),
        .DEPTH (SC)
    ) u_stamps (
        .i_clk     (i_clk),
        .i_we      (fire && stamp_we),
        .i_waddr   (r_write[AW-1:0]),
        .i_wdata   (r_in.stamp),
        .i_re      (fire),
        .i_raddr_a (r_prev[AW-1:0]),
        .i_raddr_b (r_curr[AW-1:0]),
        .o_rdata_a (ram_prev),
        .o_rdata_b (ram_curr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_curr      <= '0;
            r_write     <= '0;
            r_pin       <= '0;
            r_svalid    <= '0;
        end else begin
            if (fire) begin
                r_prev   <= n_prev;
                r_curr   <= n_curr;
                r_write  <= n_write;
                r_pin    <= n_pin;
                r_svalid <= n_svalid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in.op           <= mbsm_pkg::t_op'(i_s_tuser[mbsm_pkg::OP_W-1:0]);
            r_in.stamp        <= i_s_tdata[SW-1:0];
            r_in.release_mask <= i_s_tdata[SW +: PW];
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign prev_stamp = r_out.use_prev ? ram_prev : '0;
    assign curr_stamp = r_out.use_curr ? ram_curr : '0;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.granted;
    assign o_m_tdata  = {{mbsm_pkg::M_PAD_W{1'b0}}, curr_stamp, prev_stamp,
                         r_out.read_mask, r_out.curr_slot, r_out.prev_slot,
                         r_out.write_slot};

`include "multi_buffer_slot_manager_assert.svh"

    `MBSM_ASSERT(a_slots_in_range, i_clk, i_rst_n,
        (r_write < IW'(SC)) && (r_prev < IW'(SC)) && (r_curr < IW'(SC)),
        "slot index out of range")
    `MBSM_ASSERT(a_stall_blocks_input, i_clk, i_rst_n,
        !(r_out_valid && !i_m_tready && r_in_valid && o_s_tready),
        "input taken while pipeline full")
    `MBSM_ASSERT_NEXT(a_grant_pins, i_clk, i_rst_n, fire && grant,
        ((r_pin & r_out.read_mask) == r_out.read_mask) && (r_out.read_mask != '0),
        "granted slots not pinned")

endmodule

[rtl/mbsm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mbsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
